// File: design/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, register map, payload types and controller/datapath
// command and status bundles for the sliding window median unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WS_W           = 5;
    localparam int HELD_W         = 5;
    localparam int MAX_WINDOW_DEF = 16;

    // APB register map
    localparam int                  APB_DATA_W      = 32;
    localparam int                  APB_ADDR_W      = 3;
    localparam int                  REG_IDX_W       = 1;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [WS_W-1:0]      WS_RESET        = 5'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } swm_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic [HELD_W-1:0]          held_count;
    } swm_out_t;

    typedef struct packed {
        logic capture;   // latch the incoming sample
        logic remove;    // drop the oldest sample from ring and sorted store
        logic insert;    // write the new sample into ring and sorted store
        logic emit;      // load the median into the output register
    } swm_cmd_t;

    typedef struct packed {
        logic need_drop; // held count has reached the effective window
        logic out_free;  // output register can take a result this cycle
    } swm_status_t;

endpackage

// File: design/swm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface swm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: design/swm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/swm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: accept a sample, drop old samples until there is room,
// insert the new one, then hand the median to the output register.
// ----------------------------------------------------------------------------
module swm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t    cmd
);
    import swm_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_REMOVE = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_MEDIAN = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // ring read of the oldest slot is issued here continuously
                state_next = status.need_drop ? S_REMOVE : S_INSERT;
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_CHECK;
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_MEDIAN;
            end
            S_MEDIAN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/swm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_datapath
// Sample ring (RAM), parallel sorted register store, fill/oldest counters,
// median selection and the output register.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic [swm_pkg::WS_W-1:0]            window_size,
    input  swm_pkg::swm_cmd_t                   cmd,
    output swm_pkg::swm_status_t                status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output swm_pkg::swm_out_t                   out_data
);
    import swm_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > WS_W) ? CNT_W : WS_W;
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] sorted_reg [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sorted_next [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] ins_val [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] rem_val [MAX_WINDOW];
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic [IDX_W-1:0]           oldest_reg;
    logic [IDX_W-1:0]           oldest_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    swm_out_t                   out_data_reg;

    logic [CMP_W-1:0]           ws_ext;
    logic [CMP_W-1:0]           w_eff;
    logic [SUM_W-1:0]           slot_sum;
    logic [SUM_W-1:0]           slot_wrap;
    logic [IDX_W-1:0]           ring_waddr;
    logic [SAMPLE_W-1:0]        ring_rdata;
    logic signed [SAMPLE_W-1:0] old_val;

    logic                       gt_cur;
    logic                       gt_prev;
    logic signed [SAMPLE_W-1:0] s_prev;
    logic                       seen;

    logic [IDX_W-1:0]           mid_idx;
    logic [IDX_W-1:0]           lo_idx;
    logic signed [SAMPLE_W-1:0] mid_hi;
    logic signed [SAMPLE_W-1:0] mid_lo;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W:0]   pair_adj;
    logic signed [SAMPLE_W-1:0] median_val;

    // effective window: zero means one, saturate at the store depth
    always_comb
    begin
        ws_ext = CMP_W'(window_size);
        priority if (ws_ext == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (ws_ext > CMP_W'(MAX_WINDOW))
        begin
            w_eff = CMP_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = ws_ext;
        end
    end

    assign status.need_drop = (CMP_W'(fill_reg) >= w_eff);
    assign status.out_free  = !out_valid_reg || out_ready;

    // ring slot for the new sample: oldest + fill, wrapped once
    assign slot_sum   = SUM_W'(oldest_reg) + SUM_W'(fill_reg);
    assign slot_wrap  = (slot_sum >= SUM_W'(MAX_WINDOW)) ?
                        (slot_sum - SUM_W'(MAX_WINDOW)) : slot_sum;
    assign ring_waddr = slot_wrap[IDX_W-1:0];

    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.insert),
        .waddr (ring_waddr),
        .wdata (sample_reg),
        .raddr (oldest_reg),
        .rdata (ring_rdata)
    );

    assign old_val = ring_rdata;

    // insert: entries above the new value shift up by one
    always_comb
    begin
        gt_prev = 1'b0;
        s_prev  = sample_reg;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            gt_cur = (CNT_W'(j) < fill_reg) && (sorted_reg[j] > sample_reg);
            if ((CNT_W'(j) < fill_reg) && !gt_cur)
            begin
                ins_val[j] = sorted_reg[j];
            end
            else if (gt_prev)
            begin
                ins_val[j] = s_prev;
            end
            else
            begin
                ins_val[j] = sample_reg;
            end
            gt_prev = gt_cur;
            s_prev  = sorted_reg[j];
        end
    end

    // remove: first held entry equal to the oldest sample closes the gap
    always_comb
    begin
        seen = 1'b0;
        for (int j = 0; j < MAX_WINDOW - 1; j++)
        begin
            seen       = seen || ((CNT_W'(j) < fill_reg) && (sorted_reg[j] == old_val));
            rem_val[j] = seen ? sorted_reg[j + 1] : sorted_reg[j];
        end
        rem_val[MAX_WINDOW - 1] = sorted_reg[MAX_WINDOW - 1];
    end

    always_comb
    begin
        priority if (cmd.insert)
        begin
            sorted_next = ins_val;
        end
        else if (cmd.remove)
        begin
            sorted_next = rem_val;
        end
        else
        begin
            sorted_next = sorted_reg;
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (cmd.remove)
        begin
            fill_next   = fill_reg - 1'b1;
            oldest_next = (oldest_reg == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
        end
        else if (cmd.insert)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    // median from the middle of the sorted store
    assign mid_idx  = IDX_W'(fill_reg >> 1);
    assign lo_idx   = mid_idx - 1'b1;
    assign mid_hi   = sorted_reg[mid_idx];
    assign mid_lo   = sorted_reg[lo_idx];
    assign pair_sum = {mid_lo[SAMPLE_W-1], mid_lo} + {mid_hi[SAMPLE_W-1], mid_hi};
    // halve toward zero: bias negative sums by one before the shift
    assign pair_adj = pair_sum + (SAMPLE_W + 1)'(pair_sum[SAMPLE_W]);

    assign median_val = fill_reg[0] ? mid_hi : pair_adj[SAMPLE_W:1];

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.emit)
        begin
            out_data_reg.median     <= median_val;
            out_data_reg.held_count <= HELD_W'(fill_reg);
        end
        sorted_reg <= sorted_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: design/sliding_window_median_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running median over the most recent window_size signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one signed 16-bit sample per transaction.
//   medians : source channel, one result per sample: the median of the held
//             samples and the number of samples held after this one.
//   APB     : register 0 (byte address 0) is window_size, 5 bits, reset 5.
//             Zero acts as one, values above MAX_WINDOW saturate. Write it
//             only while the unit is idle; reset after changing it.
// Sequence:
//   After a sample is accepted the sequencer checks for room, drops one
//   old sample per pass of CHECK and REMOVE while the window is full,
//   inserts the new sample and loads the result into the output register
//   once it is free; only then does the input reopen. The drop loop is
//   bound by the single read port of the sample ring: each oldest sample
//   is fetched in CHECK, then removed from the sorted store in REMOVE.
// Reset:
//   Clears the held count, the ring pointer and the output valid; window_size
//   returns to 5. No clearing pass: stale entries are never read.
// Stall:
//   A finished result waits in the output register; the next sample is
//   accepted and processed meanwhile, and waits before the output register
//   until the receiver takes the previous transaction.
// ----------------------------------------------------------------------------
module sliding_window_median_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    swm_stream_if.sink                        samples,
    swm_stream_if.source                      medians,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import swm_pkg::*;

    logic [WS_W-1:0]      window_size_reg;
    logic [WS_W-1:0]      window_size_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    swm_cmd_t             cmd;
    swm_status_t          status;
    swm_in_t              in_data;
    swm_out_t             out_data;
    logic                 out_valid;

    // ---------------- configuration port ----------------
    // No wait states; writes land on the access phase.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        window_size_next = window_size_reg;
        if (cfg_write && (reg_idx == REG_WINDOW_SIZE))
        begin
            window_size_next = pwdata[WS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_RESET;
        end
        else
        begin
            window_size_reg <= window_size_next;
        end
    end

    // Read back the register; unmapped addresses read zero.
    assign prdata = (reg_idx == REG_WINDOW_SIZE) ? APB_DATA_W'(window_size_reg) : '0;

    // ---------------- controller ----------------
    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // ---------------- datapath ----------------
    assign in_data = samples.payload;

    swm_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (in_data.sample),
        .window_size (window_size_reg),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (medians.ready),
        .out_data    (out_data)
    );

    // Drive the result channel straight from the output register.
    assign medians.valid   = out_valid;
    assign medians.payload = out_data;

endmodule

// File: design/swm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding window median unit, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [swm_pkg::HELD_W-1:0] held_count
);
    import swm_pkg::*;

    // One sample at a time: the input closes right after a transaction.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("samples ready stayed high after a transaction");

    // A result always reports at least one and at most the store depth.
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((held_count != '0) && (int'(held_count) <= MAX_WINDOW)))
        else $error("held_count out of range");

    // Hold a stalled result.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind sliding_window_median_unit swm_checker #(
    .MAX_WINDOW (MAX_WINDOW)
) u_swm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (medians.valid),
    .out_ready  (medians.ready),
    .held_count (medians.payload.held_count)
);
